// ===== hw/rtl/lrmp_pkg.sv =====
// shared types and constants of the linear recurrence matrix power unit
package lrmp_pkg;

  localparam int MAX_ORDER = 16;
  localparam int MOD_W     = 30;
  localparam int DIM       = MAX_ORDER + 1;
  localparam int AW        = $clog2(DIM * DIM);
  localparam int CW        = $clog2(DIM);
  localparam int IW        = $clog2(MAX_ORDER);
  localparam int OPER_W    = 32;
  localparam int CHAIN_LEN = OPER_W - 1;
  localparam int FLY_W     = $clog2(CHAIN_LEN + 4);
  localparam int ORD_W     = 5;
  localparam int SLOT_W    = 5;
  localparam int OPC_W     = 2;
  localparam int TERM_W    = 60;
  localparam int NBANK     = 3;
  localparam int BANK_W    = 2;

  localparam logic [OPC_W-1:0] OP_LOAD_COEF = 2'd0;
  localparam logic [OPC_W-1:0] OP_LOAD_INIT = 2'd1;
  localparam logic [OPC_W-1:0] OP_QUERY     = 2'd2;

  typedef logic [BANK_W-1:0] bank_t;

  typedef enum logic {
    DEST_BANK,
    DEST_OUT
  } dest_t;

  typedef struct packed {
    logic          first;
    logic          last;
    dest_t         dest;
    bank_t         bank;
    logic [AW-1:0] addr;
  } tag_t;

  typedef struct packed {
    logic              valid;
    logic [MOD_W-1:0]  a;
    logic [OPER_W-1:0] b;
    tag_t              tag;
  } job_t;

  typedef struct packed {
    logic                 valid;
    logic [MOD_W-1:0]     r;
    logic [MOD_W-1:0]     a;
    logic [CHAIN_LEN-1:0] b;
    tag_t                 tag;
  } stage_t;

endpackage

// ===== hw/rtl/lrmp_if.sv =====
// item channels of the linear recurrence matrix power unit
interface lrmp_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [lrmp_pkg::OPC_W-1:0]          opcode;
  logic [lrmp_pkg::SLOT_W-1:0]         slot_index;
  logic signed [lrmp_pkg::OPER_W-1:0]  load_value;
  logic [lrmp_pkg::TERM_W-1:0]         term_index;
  logic [lrmp_pkg::MOD_W-1:0]          modulus;

  modport source (output valid, opcode, slot_index, load_value, term_index, modulus,
                  input ready);
  modport sink (input valid, opcode, slot_index, load_value, term_index, modulus,
                output ready);
endinterface

interface lrmp_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [lrmp_pkg::MOD_W-1:0] term_value;

  modport source (output valid, term_value, input ready);
  modport sink (input valid, term_value, output ready);
endinterface

// ===== hw/rtl/lrmp_ram.sv =====
// generic ram, one write port, two registered read ports
module lrmp_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 289
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end
endmodule

// ===== hw/rtl/lrmp_cell.sv =====
// one bit step of the modular multiplier chain
module lrmp_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lrmp_pkg::MOD_W-1:0] m,
  input  lrmp_pkg::stage_t           prev,
  output lrmp_pkg::stage_t           next
);
  import lrmp_pkg::*;

  logic [MOD_W:0] dbl;
  logic [MOD_W:0] dbl_red;
  logic [MOD_W:0] sum;
  logic [MOD_W:0] sum_red;
  logic [MOD_W:0] m_ext;

  always_comb begin
    m_ext   = {1'b0, m};
    dbl     = {prev.r, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum     = dbl_red + (prev.b[CHAIN_LEN-1] ? {1'b0, prev.a} : '0);
    sum_red = (sum >= m_ext) ? sum - m_ext : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else begin
      next.valid <= prev.valid;
      next.r     <= sum_red[MOD_W-1:0];
      next.a     <= prev.a;
      next.b     <= prev.b << 1;
      next.tag   <= prev.tag;
    end
  end
endmodule

// ===== hw/rtl/lrmp_chain.sv =====
// bit-serial signed multiply-mod chain, one product per cycle
module lrmp_chain (
  input  logic                       clk,
  input  logic                       rst,
  input  lrmp_pkg::job_t             job,
  input  logic [lrmp_pkg::MOD_W-1:0] m,
  output lrmp_pkg::stage_t           res
);
  import lrmp_pkg::*;

  stage_t head;
  stage_t st [CHAIN_LEN+1];

  // sign bit carries negative weight
  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid <= job.valid;
      head.r     <= (job.b[OPER_W-1] && (job.a != '0)) ? m - job.a : '0;
      head.a     <= job.a;
      head.b     <= job.b[CHAIN_LEN-1:0];
      head.tag   <= job.tag;
    end
  end

  assign st[0] = head;

  for (genvar c = 0; c < CHAIN_LEN; c++) begin : g_cell
    lrmp_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .m    (m),
      .prev (st[c]),
      .next (st[c+1])
    );
  end

  assign res = st[CHAIN_LEN];
endmodule

// ===== hw/rtl/linear_recurrence_matrix_power_mod_unit.sv =====
// top level of the linear recurrence matrix power unit
// A query with modulus 0 answers 0, one with t < N answers initial term t mod m.
// Otherwise the block builds the (N+1)-square companion and identity matrices, runs
// square-and-multiply on e = t-N+1 and dots row 1 with the initial terms. Products run
// through the single 31-cell multiply-mod chain, which takes one product per cycle and
// drains between matrix products. Matrices sit in three rams whose roles rotate, so no
// copy is needed.
// One query is worked on at a time; loads are taken only while idle, and configuration
// is to be written only while idle, which the block does not enforce.
module linear_recurrence_matrix_power_mod_unit (
  input  logic                       clk,
  input  logic                       rst,
  lrmp_cmd_if.sink                   cmd,
  lrmp_rsp_if.source                 rsp,
  input  logic                       cfg_we,
  input  logic [lrmp_pkg::ORD_W-1:0] cfg_wdata
);
  import lrmp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ZERO, S_SMALL, S_INIT_P, S_INIT_A, S_INIT_WAIT, S_STEP,
    S_MUL, S_MUL_WAIT, S_VEC, S_VEC_WAIT, S_DOT, S_DRAIN
  } state_t;

  function automatic logic [AW-1:0] mat_addr(logic [CW-1:0] r, logic [CW-1:0] c);
    return AW'(r) * AW'(DIM) + AW'(c);
  endfunction

  state_t              state;
  logic [ORD_W-1:0]    order_r;
  logic [CW-1:0]       n_r;
  logic [CW-1:0]       n_calc;
  logic [MOD_W-1:0]    m_r;
  logic                one_r;
  logic [IW-1:0]       t_small;
  logic [TERM_W-1:0]   e_r;
  logic                sq_r;
  logic [CW-1:0]       ci, ck, cj;
  bank_t               acc_bank, pow_bank, free_bank;
  logic [OPER_W-1:0]   coef [DIM];
  logic [OPER_W-1:0]   init_terms [MAX_ORDER];
  logic [FLY_W-1:0]    inflight;

  logic                iss;
  logic                iss_use_ram;
  logic [OPER_W-1:0]   iss_b;
  tag_t                iss_tag;
  logic [AW-1:0]       raddr0, raddr1;
  bank_t               xsel, ysel;
  logic [CW-1:0]       vidx;

  logic                s1_valid;
  logic                s1_use_ram;
  logic [OPER_W-1:0]   s1_b;
  tag_t                s1_tag;
  bank_t               s1_xsel, s1_ysel;

  logic [MOD_W-1:0]    rd0 [NBANK];
  logic [MOD_W-1:0]    rd1 [NBANK];
  logic                bank_we [NBANK];

  job_t                job;
  stage_t              res;
  logic [MOD_W-1:0]    acc_r;
  logic [MOD_W:0]      acc_add;
  logic [MOD_W-1:0]    sum;
  logic                rsp_valid_r;
  logic [MOD_W-1:0]    rsp_value_r;

  assign cmd.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_valid_r;
  assign rsp.term_value = rsp_value_r;

  always_comb begin
    if (order_r == '0) begin
      n_calc = CW'(1);
    end else if (CW'(order_r) > CW'(MAX_ORDER)) begin
      n_calc = CW'(MAX_ORDER);
    end else begin
      n_calc = CW'(order_r);
    end
  end

  // issue side
  always_comb begin
    iss           = 1'b0;
    iss_use_ram   = 1'b0;
    iss_b         = '0;
    iss_tag       = '0;
    iss_tag.first = 1'b1;
    iss_tag.last  = 1'b1;
    iss_tag.dest  = DEST_BANK;
    raddr0        = '0;
    raddr1        = '0;
    xsel          = acc_bank;
    ysel          = pow_bank;
    vidx          = n_r - ci;
    case (state)
      S_SMALL: begin
        iss          = !rsp_valid_r;
        iss_b        = init_terms[t_small];
        iss_tag.dest = DEST_OUT;
      end
      S_INIT_P: begin
        iss          = 1'b1;
        if (ci == CW'(1)) begin
          iss_b = coef[ck];
        end else if (((ci == '0) && (ck == '0)) ||
                     ((ci >= CW'(2)) && (ck == ci - CW'(1)))) begin
          iss_b = OPER_W'(1);
        end
        iss_tag.bank = pow_bank;
        iss_tag.addr = mat_addr(ci, ck);
      end
      S_INIT_A: begin
        iss          = 1'b1;
        iss_b        = OPER_W'(ci == ck);
        iss_tag.bank = acc_bank;
        iss_tag.addr = mat_addr(ci, ck);
      end
      S_MUL: begin
        iss           = 1'b1;
        iss_use_ram   = 1'b1;
        raddr0        = mat_addr(ci, cj);
        raddr1        = mat_addr(cj, ck);
        xsel          = sq_r ? pow_bank : acc_bank;
        iss_tag.first = (cj == '0);
        iss_tag.last  = (cj == n_r);
        iss_tag.bank  = free_bank;
        iss_tag.addr  = mat_addr(ci, ck);
      end
      S_VEC: begin
        iss          = 1'b1;
        iss_b        = (ci == '0) ? OPER_W'(1) : init_terms[vidx[IW-1:0]];
        iss_tag.bank = free_bank;
        iss_tag.addr = AW'(ci);
      end
      S_DOT: begin
        iss           = !rsp_valid_r;
        iss_use_ram   = 1'b1;
        raddr0        = mat_addr(CW'(1), cj);
        raddr1        = AW'(cj);
        ysel          = free_bank;
        iss_tag.first = (cj == '0);
        iss_tag.last  = (cj == n_r);
        iss_tag.dest  = DEST_OUT;
      end
      default: begin
        iss = 1'b0;
      end
    endcase
  end

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    assign bank_we[b] = res.valid && res.tag.last && (res.tag.dest == DEST_BANK) &&
                        (res.tag.bank == BANK_W'(b));
    lrmp_ram #(.WIDTH(MOD_W), .DEPTH(DIM * DIM)) u_ram (
      .clk    (clk),
      .we     (bank_we[b]),
      .waddr  (res.tag.addr),
      .wdata  (sum),
      .raddr0 (raddr0),
      .raddr1 (raddr1),
      .rdata0 (rd0[b]),
      .rdata1 (rd1[b])
    );
  end

  always_comb begin
    job.valid = s1_valid;
    job.a     = s1_use_ram ? rd0[s1_xsel] : {{(MOD_W-1){1'b0}}, one_r};
    job.b     = s1_use_ram ? OPER_W'(rd1[s1_ysel]) : s1_b;
    job.tag   = s1_tag;
  end

  lrmp_chain u_chain (
    .clk (clk),
    .rst (rst),
    .job (job),
    .m   (m_r),
    .res (res)
  );

  always_comb begin
    acc_add = {1'b0, acc_r} + {1'b0, res.r};
    if (acc_add >= {1'b0, m_r}) begin
      acc_add = acc_add - {1'b0, m_r};
    end
    sum = res.tag.first ? res.r : acc_add[MOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      order_r     <= ORD_W'(1);
      s1_valid    <= 1'b0;
      inflight    <= '0;
      rsp_valid_r <= 1'b0;
      acc_bank    <= BANK_W'(0);
      pow_bank    <= BANK_W'(1);
      free_bank   <= BANK_W'(2);
      e_r         <= '0;
    end else begin
      if (cfg_we) begin
        order_r <= cfg_wdata;
      end

      s1_valid   <= iss;
      s1_use_ram <= iss_use_ram;
      s1_b       <= iss_b;
      s1_tag     <= iss_tag;
      s1_xsel    <= xsel;
      s1_ysel    <= ysel;

      case ({iss, res.valid})
        2'b10:   inflight <= inflight + FLY_W'(1);
        2'b01:   inflight <= inflight - FLY_W'(1);
        default: inflight <= inflight;
      endcase

      if (rsp_valid_r && rsp.ready) begin
        rsp_valid_r <= 1'b0;
      end
      if (res.valid) begin
        acc_r <= sum;
        if (res.tag.last && (res.tag.dest == DEST_OUT)) begin
          rsp_valid_r <= 1'b1;
          rsp_value_r <= sum;
        end
      end

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            case (cmd.opcode)
              OP_LOAD_COEF: begin
                if (cmd.slot_index <= SLOT_W'(MAX_ORDER)) begin
                  coef[CW'(cmd.slot_index)] <= cmd.load_value;
                end
              end
              OP_LOAD_INIT: begin
                if (cmd.slot_index < SLOT_W'(MAX_ORDER)) begin
                  init_terms[cmd.slot_index[IW-1:0]] <= cmd.load_value;
                end
              end
              OP_QUERY: begin
                m_r     <= cmd.modulus;
                one_r   <= (cmd.modulus != MOD_W'(1));
                n_r     <= n_calc;
                t_small <= cmd.term_index[IW-1:0];
                e_r     <= cmd.term_index - TERM_W'(n_calc) + TERM_W'(1);
                ci      <= '0;
                ck      <= '0;
                cj      <= '0;
                if (cmd.modulus == '0) begin
                  state <= S_ZERO;
                end else if (cmd.term_index < TERM_W'(n_calc)) begin
                  state <= S_SMALL;
                end else begin
                  state <= S_INIT_P;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_ZERO: begin
          if (!rsp_valid_r) begin
            rsp_valid_r <= 1'b1;
            rsp_value_r <= '0;
            state       <= S_IDLE;
          end
        end
        S_SMALL: begin
          if (iss) begin
            state <= S_DRAIN;
          end
        end
        S_INIT_P, S_INIT_A: begin
          if (ck == n_r) begin
            ck <= '0;
            if (ci == n_r) begin
              ci    <= '0;
              state <= (state == S_INIT_P) ? S_INIT_A : S_INIT_WAIT;
            end else begin
              ci <= ci + CW'(1);
            end
          end else begin
            ck <= ck + CW'(1);
          end
        end
        S_INIT_WAIT: begin
          if (inflight == '0) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          ci <= '0;
          ck <= '0;
          cj <= '0;
          if (e_r == '0) begin
            state <= S_VEC;
          end else if (e_r[0]) begin
            sq_r   <= 1'b0;
            e_r[0] <= 1'b0;
            state  <= S_MUL;
          end else begin
            sq_r  <= 1'b1;
            e_r   <= e_r >> 1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (cj == n_r) begin
            cj <= '0;
            if (ck == n_r) begin
              ck <= '0;
              if (ci == n_r) begin
                ci    <= '0;
                state <= S_MUL_WAIT;
              end else begin
                ci <= ci + CW'(1);
              end
            end else begin
              ck <= ck + CW'(1);
            end
          end else begin
            cj <= cj + CW'(1);
          end
        end
        S_MUL_WAIT: begin
          if (inflight == '0) begin
            if (sq_r) begin
              pow_bank  <= free_bank;
              free_bank <= pow_bank;
            end else begin
              acc_bank  <= free_bank;
              free_bank <= acc_bank;
            end
            state <= S_STEP;
          end
        end
        S_VEC: begin
          if (ci == n_r) begin
            ci    <= '0;
            state <= S_VEC_WAIT;
          end else begin
            ci <= ci + CW'(1);
          end
        end
        S_VEC_WAIT: begin
          if (inflight == '0) begin
            cj    <= '0;
            state <= S_DOT;
          end
        end
        S_DOT: begin
          if (iss) begin
            if (cj == n_r) begin
              state <= S_DRAIN;
            end else begin
              cj <= cj + CW'(1);
            end
          end
        end
        S_DRAIN: begin
          if (inflight == '0) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ap_out_free: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.tag.last && (res.tag.dest == DEST_OUT)) |-> !rsp_valid_r)
    else $error("result overwrites a pending item");

  ap_bank_roles: assert property (@(posedge clk) disable iff (rst)
    (acc_bank != pow_bank) && (acc_bank != free_bank) && (pow_bank != free_bank))
    else $error("matrix bank roles collide");

  ap_fly_count: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (inflight != '0))
    else $error("chain output without issued job");

  ap_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((inflight == '0) && !s1_valid))
    else $error("idle with jobs in flight");
endmodule
